// ----- sv/butterworth_biquad_3ch_unit_defines.svh -----
// ----------------------------------------------------------------------------
// butterworth_biquad_3ch_unit_defines.svh - assertion macros
// Shared assertion shorthands for the biquad filter checkers.
// ----------------------------------------------------------------------------
`ifndef BUTTERWORTH_BIQUAD_3CH_UNIT_DEFINES_SVH
`define BUTTERWORTH_BIQUAD_3CH_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BBQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbq assertion failed");

// next-cycle implication, disabled during reset
`define BBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbq assertion failed");

`endif

// ----- sv/bbq_pkg.sv -----
// ----------------------------------------------------------------------------
// bbq_pkg - shared types and constants
// Register indexes, fixed widths and the control bundle of the biquad unit.
// ----------------------------------------------------------------------------
package bbq_pkg;

  // width of the warm-up count register
  localparam int FILL_W = 8;
  // width of the register index on the config port
  localparam int CFG_IDX_W = 2;
  // warm-up count after reset
  localparam logic [FILL_W-1:0] FILL_RESET = 8'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0    = 2'd0,
    REG_COEF_A1    = 2'd1,
    REG_COEF_A2    = 2'd2,
    REG_FILL_COUNT = 2'd3
  } cfg_reg_t;

  // pipeline control from the sequencer to the datapath
  typedef struct packed {
    logic load;  // input beat taken into the input register
    logic step;  // input register moves to the result register
    logic warm;  // item in the input register passes through unfiltered
  } bbq_ctrl_t;

endpackage

// ----- sv/butterworth_biquad_3ch_unit.sv -----
// ----------------------------------------------------------------------------
// butterworth_biquad_3ch_unit - three-axis second-order low-pass filter
// Per-axis biquad with Q4.14 coefficients, warm-up pass-through and
// saturated results on a streaming interface.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_* carry one sample per axis; each gives exactly one
//   result beat on m_*, with m_tuser set when the item was passed through
//   during warm-up. Coefficients and the warm-up count are written on the
//   cfg_* port while the stream is idle.
// Timing:
//   A beat taken into the input register is filtered combinationally and
//   lands in the result register once that register is empty or being
//   drained. One beat per cycle is sustained while m_tready stays high; the
//   limit is the per-axis loop of three multiplies, the sum, the rounding
//   shift and the saturation feeding back into the history.
// Reset:
//   Clears history, warm-up count, coefficients (fill count back to 3) and
//   both valid flags.
// Stall:
//   A held result keeps m_* steady; one further beat is taken into the input
//   register, after which s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module butterworth_biquad_3ch_unit #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 14,
  parameter int LANES          = 3,
  localparam int COEF_W        = COEF_FRAC_BITS + 4,
  localparam int DATA_W        = ((LANES * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int CFG_W         = (COEF_W > bbq_pkg::FILL_W) ? COEF_W : bbq_pkg::FILL_W
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [DATA_W-1:0]              s_tdata,   // sample_x, sample_y, sample_z
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [DATA_W-1:0]              m_tdata,   // filt_x, filt_y, filt_z
  output logic                           m_tuser,   // warming_up
  // configuration writes
  input  logic                           cfg_we,
  input  logic [bbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);
  import bbq_pkg::*;

  localparam int LANE_BITS = LANES * SAMPLE_WIDTH;

  logic signed [COEF_W-1:0] coef_b0, coef_a1, coef_a2;
  logic [FILL_W-1:0]        fill_count;
  bbq_ctrl_t                ctrl;
  logic [LANE_BITS-1:0]     in_data;
  logic [LANE_BITS-1:0]     filt_data;
  logic [LANE_BITS-1:0]     out_data;
  logic                     out_warm;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0    <= '0;
      coef_a1    <= '0;
      coef_a2    <= '0;
      fill_count <= FILL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_B0:    coef_b0    <= cfg_data[COEF_W-1:0];
        REG_COEF_A1:    coef_a1    <= cfg_data[COEF_W-1:0];
        REG_COEF_A2:    coef_a2    <= cfg_data[COEF_W-1:0];
        REG_FILL_COUNT: fill_count <= cfg_data[FILL_W-1:0];
        default:        ;
      endcase
    end
  end

  // handshake and warm-up control
  bbq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .fill_count (fill_count),
    .ctrl       (ctrl)
  );

  // input register
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      in_data <= s_tdata[LANE_BITS-1:0];
    end
  end

  // one biquad per axis
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bbq_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .coef_b0 (coef_b0),
      .coef_a1 (coef_a1),
      .coef_a2 (coef_a2),
      .sample  (in_data[g*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
      .filt    (filt_data[g*SAMPLE_WIDTH +: SAMPLE_WIDTH])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      out_data <= filt_data;
      out_warm <= ctrl.warm;
    end
  end

  assign m_tdata = DATA_W'(out_data);
  assign m_tuser = out_warm;

endmodule

// ----- sv/bbq_lane.sv -----
// ----------------------------------------------------------------------------
// bbq_lane - one axis of the biquad
// Two-tap input and output history and the combinational difference equation
// with round-half-up, floor shift and saturation.
// ----------------------------------------------------------------------------
module bbq_lane #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 14,
  localparam int COEF_W        = COEF_FRAC_BITS + 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bbq_pkg::bbq_ctrl_t             ctrl,
  input  logic signed [COEF_W-1:0]       coef_b0,
  input  logic signed [COEF_W-1:0]       coef_a1,
  input  logic signed [COEF_W-1:0]       coef_a2,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] filt
);
  import bbq_pkg::*;

  localparam int XS_W  = SAMPLE_WIDTH + 2;
  localparam int PB_W  = COEF_W + XS_W;
  localparam int PA_W  = COEF_W + SAMPLE_WIDTH;
  localparam int ACC_W = PB_W + 1;
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [SAMPLE_WIDTH-1:0] x1, x2, y1, y2;
  logic signed [XS_W-1:0]         xs;
  logic signed [PB_W-1:0]         prod_b;
  logic signed [PA_W-1:0]         prod_a1, prod_a2;
  logic signed [ACC_W-1:0]        acc, shifted;
  logic                           fits;
  logic signed [SAMPLE_WIDTH-1:0] sat;

  // numerator: b0 * (x + 2*x1 + x2), feedback: a1*y1 + a2*y2
  always_comb begin
    xs      = XS_W'(sample) + (XS_W'(x1) <<< 1) + XS_W'(x2);
    prod_b  = PB_W'(coef_b0) * PB_W'(xs);
    prod_a1 = PA_W'(coef_a1) * PA_W'(y1);
    prod_a2 = PA_W'(coef_a2) * PA_W'(y2);
    acc     = ACC_W'(prod_b) - ACC_W'(prod_a1) - ACC_W'(prod_a2) + ROUND_HALF;
    shifted = acc >>> COEF_FRAC_BITS;
  end

  // saturate: in range when all bits above the sample sign agree with it
  always_comb begin
    fits = (shifted[ACC_W-1:SAMPLE_WIDTH-1] == '0) ||
           (shifted[ACC_W-1:SAMPLE_WIDTH-1] == '1);
    if (fits) begin
      sat = shifted[SAMPLE_WIDTH-1:0];
    end else begin
      sat = {shifted[ACC_W-1], {(SAMPLE_WIDTH-1){~shifted[ACC_W-1]}}};
    end
    filt = ctrl.warm ? sample : sat;
  end

  // history shifts once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (ctrl.step) begin
      x2 <= x1;
      x1 <= sample;
      y2 <= y1;
      y1 <= filt;
    end
  end

endmodule

// ----- sv/bbq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbq_ctrl - handshake and warm-up sequencing
// Valid tracking for the input and result registers, and the warm-up count.
// ----------------------------------------------------------------------------
module bbq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [bbq_pkg::FILL_W-1:0]  fill_count,
  output bbq_pkg::bbq_ctrl_t          ctrl
);
  import bbq_pkg::*;

  logic              in_valid, in_valid_next;
  logic              out_valid, out_valid_next;
  logic [FILL_W-1:0] items_seen, items_seen_next;

  // item moves on when the result register is empty or being drained
  always_comb begin
    ctrl.step = in_valid && (!out_valid || m_tready);
    ctrl.warm = items_seen < fill_count;
    s_tready  = !in_valid || ctrl.step;
    ctrl.load = s_tvalid && s_tready;
    m_tvalid  = out_valid;
  end

  // next-state values
  always_comb begin
    priority if (ctrl.load) begin
      in_valid_next = 1'b1;
    end else if (ctrl.step) begin
      in_valid_next = 1'b0;
    end else begin
      in_valid_next = in_valid;
    end
    priority if (ctrl.step) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
    // count stops once warm-up is over, so it never wraps
    items_seen_next = (ctrl.step && ctrl.warm) ? items_seen + 1'b1 : items_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      items_seen <= '0;
    end else begin
      in_valid   <= in_valid_next;
      out_valid  <= out_valid_next;
      items_seen <= items_seen_next;
    end
  end

endmodule

// ----- sv/bbq_checker.sv -----
// ----------------------------------------------------------------------------
// bbq_checker - port-level checks for the biquad unit
// Watches the two stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "butterworth_biquad_3ch_unit_defines.svh"

module bbq_checker #(
  parameter int DATA_W = 48
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tuser
);

  // a stalled result beat holds
  `BBQ_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // nothing offered right after reset
  `BBQ_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_tvalid)

  // with the result register empty the input side is always open
  `BBQ_ASSERT_NOW(a_ready_empty, clk, rst, !m_tvalid, s_tready)

  // an accepted beat leads to a valid beat on the result side
  `BBQ_ASSERT_NEXT(a_latency, clk, rst, s_tvalid && s_tready, ##1 m_tvalid)

endmodule

bind butterworth_biquad_3ch_unit bbq_checker #(.DATA_W(DATA_W)) u_bbq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
